// ===== hdl/cmrm_pkg.sv =====
// Shared types and constants of the column-major to row-major address unit.
`timescale 1ns / 1ps

package cmrm_pkg;

	// Default sizes of the unit.
	localparam int MAX_RANK_DEF   = 4;
	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;
	localparam int DATA_BITS_DEF  = 64;

	// Fixed widths of the configuration port.
	localparam int RANK_BITS    = 3;
	localparam int CFG_IDX_BITS = 3;

	// Number of size registers in the register map.
	localparam int CFG_SIZE_REGS = 4;

	// Register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_RANK = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIM0 = 3'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init;        // start a stride setup
		logic stride_en;   // one step of the stride pass
		logic delta_en;    // one step of the offset increment pass
		logic step;        // an item is accepted
	} cmrm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cfg_hit;     // a register write that restarts the tensor
	} cmrm_sts_t;

endpackage

// ===== hdl/col_major_to_row_major_address_unit.sv =====
// Top level of the column-major to row-major address unit.
`timescale 1ns / 1ps

// Elements of a tensor enter on the input channel (in_valid, in_stall,
// element_in) in column-major order, dimension 0 fastest. Each one leaves on
// the output channel (out_valid, out_stall) with its row-major destination
// index, a flag on the last element of the tensor, and an overflow flag that
// is high for the whole tensor when the element count exceeds the index range.
// Rank and dimension sizes are written on the cfg_valid/cfg_ready port, only
// while no item is in flight; every write to the rank or a size register
// restarts the tensor. After reset or such a write, the first item is held
// while the strides and counter increments are set up: one dimension per
// cycle through a single shared multiplier, in two passes.
// From then on one item is accepted per cycle unless the receiver stalls,
// across tensor boundaries as well, and its result stands in the output
// register in the cycle after acceptance. While the receiver stalls,
// the output register holds its item and one more item is not taken until it drains.
// Reset sets rank 1 and all sizes 1 and clears the counters and the offset.

module col_major_to_row_major_address_unit #(
	parameter int MAX_RANK   = cmrm_pkg::MAX_RANK_DEF,
	parameter int DIM_BITS   = cmrm_pkg::DIM_BITS_DEF,
	parameter int INDEX_BITS = cmrm_pkg::INDEX_BITS_DEF,
	parameter int DATA_BITS  = cmrm_pkg::DATA_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cmrm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]               cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [DATA_BITS-1:0]              element_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [INDEX_BITS-1:0]             dest_index,
	output logic [DATA_BITS-1:0]              element_out,
	output logic                              last_element,
	output logic                              index_overflow
);

	localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

	cmrm_pkg::cmrm_cmd_t cmd;
	cmrm_pkg::cmrm_sts_t sts;
	logic [IW-1:0]       idx;
	logic [IW-1:0]       rank_last;

	// Controller.
	cmrm_ctrl #(
		.IW (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.rank_last (rank_last),
		.cmd       (cmd),
		.idx       (idx)
	);

	// Datapath.
	cmrm_datapath #(
		.MAX_RANK   (MAX_RANK),
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS),
		.DATA_BITS  (DATA_BITS),
		.IW         (IW)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.idx            (idx),
		.sts            (sts),
		.rank_last      (rank_last),
		.element_in     (element_in),
		.dest_index     (dest_index),
		.element_out    (element_out),
		.last_element   (last_element),
		.index_overflow (index_overflow)
	);

endmodule

// ===== hdl/cmrm_datapath.sv =====
// Datapath: configuration registers, stride setup, digit counters and output register.
`timescale 1ns / 1ps

module cmrm_datapath #(
	parameter int MAX_RANK   = cmrm_pkg::MAX_RANK_DEF,
	parameter int DIM_BITS   = cmrm_pkg::DIM_BITS_DEF,
	parameter int INDEX_BITS = cmrm_pkg::INDEX_BITS_DEF,
	parameter int DATA_BITS  = cmrm_pkg::DATA_BITS_DEF,
	parameter int IW         = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cmrm_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [DIM_BITS-1:0]               cfg_data,
	input  cmrm_pkg::cmrm_cmd_t               cmd,
	input  logic [IW-1:0]                     idx,
	output cmrm_pkg::cmrm_sts_t               sts,
	output logic [IW-1:0]                     rank_last,
	input  logic [DATA_BITS-1:0]              element_in,
	output logic [INDEX_BITS-1:0]             dest_index,
	output logic [DATA_BITS-1:0]              element_out,
	output logic                              last_element,
	output logic                              index_overflow
);

	localparam int PW = INDEX_BITS + DIM_BITS;
	localparam logic [PW-1:0] LIMIT = PW'(1) << INDEX_BITS;
	localparam logic [3:0] MAX_RANK_W = 4'(MAX_RANK);

	// Configuration registers.
	logic [cmrm_pkg::RANK_BITS-1:0] rank_q;
	logic [DIM_BITS-1:0]            size_q [MAX_RANK];

	// Tensor walk state.
	logic [DIM_BITS-1:0]   cnt_q [MAX_RANK];
	logic [INDEX_BITS-1:0] offset_q;
	logic                  ovf_q;
	logic                  at_lim_q;

	// Setup results and accumulators.
	logic [INDEX_BITS-1:0] stride_q [MAX_RANK];
	logic [INDEX_BITS-1:0] delta_q [MAX_RANK];
	logic [INDEX_BITS-1:0] modp_q;
	logic [INDEX_BITS-1:0] back_q;

	// Output register.
	logic [INDEX_BITS-1:0] dest_index_q;
	logic [DATA_BITS-1:0]  element_q;
	logic                  last_q;
	logic                  index_ovf_q;

	logic [DIM_BITS-1:0]   eff [MAX_RANK];
	logic [3:0]            used_rank;
	logic                  rank_wr;
	logic                  size_wr;
	logic [cmrm_pkg::CFG_IDX_BITS-1:0] size_sel;
	logic [PW-1:0]         prod;
	logic [INDEX_BITS-1:0] mul_a;
	logic [DIM_BITS-1:0]   mul_b;
	logic                  ovf_n;
	logic                  at_lim_n;
	logic                  last_c;
	logic                  found;
	logic [IW-1:0]         pos;
	logic [DIM_BITS-1:0]   cnt_n [MAX_RANK];
	logic [INDEX_BITS-1:0] offset_n;

	// Register write decode: size registers beyond the rank limit are ignored.
	always_comb begin
		size_sel = cfg_index - cmrm_pkg::REG_DIM0;
		rank_wr  = cfg_we && (cfg_index == cmrm_pkg::REG_RANK);
		size_wr  = cfg_we && (cfg_index >= cmrm_pkg::REG_DIM0)
			&& (int'(size_sel) < cmrm_pkg::CFG_SIZE_REGS) && (int'(size_sel) < MAX_RANK);
	end

	assign sts.cfg_hit = rank_wr || size_wr;

	// Rank in use, with zero read as one and large values saturated.
	always_comb begin
		if (rank_q == '0) begin
			used_rank = 4'd1;
		end else if (4'(rank_q) > MAX_RANK_W) begin
			used_rank = MAX_RANK_W;
		end else begin
			used_rank = 4'(rank_q);
		end
		rank_last = IW'(used_rank - 4'd1);
	end

	// Effective sizes: a size of zero counts as one.
	always_comb begin
		for (int k = 0; k < MAX_RANK; k++) begin
			eff[k] = (size_q[k] == '0) ? DIM_BITS'(1) : size_q[k];
		end
	end

	// Shared multiplier of both setup passes.
	always_comb begin
		if (cmd.stride_en) begin
			mul_a = modp_q;
			mul_b = eff[idx];
		end else begin
			mul_a = stride_q[idx];
			mul_b = eff[idx] - DIM_BITS'(1);
		end
		prod = PW'(mul_a) * PW'(mul_b);
	end

	// Overflow tracking: the exact product either is still below the limit,
	// sits exactly on it, or has gone past it.
	always_comb begin
		if (at_lim_q) begin
			ovf_n = ovf_q || (eff[idx] != DIM_BITS'(1));
		end else begin
			ovf_n = ovf_q || (prod > LIMIT);
		end
		at_lim_n = !ovf_n && (at_lim_q || (prod == LIMIT));
	end

	// Counter advance: the lowest digit that is not at its maximum counts up,
	// the digits below it wrap to zero.
	always_comb begin
		last_c = 1'b1;
		found  = 1'b0;
		pos    = '0;
		for (int k = 0; k < MAX_RANK; k++) begin
			if ((IW'(k) <= rank_last) && (cnt_q[k] != eff[k] - DIM_BITS'(1))) begin
				last_c = 1'b0;
				if (!found) begin
					found = 1'b1;
					pos   = IW'(k);
				end
			end
		end
		for (int k = 0; k < MAX_RANK; k++) begin
			if (last_c || (IW'(k) < pos)) begin
				cnt_n[k] = '0;
			end else if (IW'(k) == pos) begin
				cnt_n[k] = cnt_q[k] + DIM_BITS'(1);
			end else begin
				cnt_n[k] = cnt_q[k];
			end
		end
		offset_n = last_c ? '0 : offset_q + delta_q[pos];
	end

	// Configuration and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= cmrm_pkg::RANK_BITS'(1);
			offset_q <= '0;
			ovf_q    <= 1'b0;
			at_lim_q <= 1'b0;
			for (int k = 0; k < MAX_RANK; k++) begin
				size_q[k] <= DIM_BITS'(1);
				cnt_q[k]  <= '0;
			end
		end else if (sts.cfg_hit) begin
			if (rank_wr) begin
				rank_q <= cfg_data[cmrm_pkg::RANK_BITS-1:0];
			end
			for (int k = 0; k < MAX_RANK; k++) begin
				if (size_wr && (IW'(k) == IW'(size_sel))) begin
					size_q[k] <= cfg_data;
				end
				cnt_q[k] <= '0;
			end
			offset_q <= '0;
			ovf_q    <= 1'b0;
			at_lim_q <= 1'b0;
		end else if (cmd.init) begin
			ovf_q    <= 1'b0;
			at_lim_q <= 1'b0;
		end else if (cmd.stride_en) begin
			ovf_q    <= ovf_n;
			at_lim_q <= at_lim_n;
		end else if (cmd.step) begin
			for (int k = 0; k < MAX_RANK; k++) begin
				cnt_q[k] <= cnt_n[k];
			end
			offset_q <= offset_n;
		end
	end

	// Strides, offset increments and setup accumulators.
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			modp_q <= INDEX_BITS'(1);
			back_q <= '0;
		end else if (cmd.stride_en) begin
			stride_q[idx] <= modp_q;
			modp_q        <= prod[INDEX_BITS-1:0];
		end else if (cmd.delta_en) begin
			delta_q[idx] <= stride_q[idx] - back_q;
			back_q       <= back_q + prod[INDEX_BITS-1:0];
		end
	end

	// Output register, loaded with each accepted item.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			dest_index_q <= offset_q;
			element_q    <= element_in;
			last_q       <= last_c;
			index_ovf_q  <= ovf_q;
		end
	end

	assign dest_index     = dest_index_q;
	assign element_out    = element_q;
	assign last_element   = last_q;
	assign index_overflow = index_ovf_q;

endmodule

// ===== hdl/cmrm_ctrl.sv =====
// Controller: stride setup sequencing and the item handshakes.
`timescale 1ns / 1ps

module cmrm_ctrl #(
	parameter int IW = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                cfg_ready,
	input  cmrm_pkg::cmrm_sts_t sts,
	input  logic [IW-1:0]       rank_last,
	output cmrm_pkg::cmrm_cmd_t cmd,
	output logic [IW-1:0]       idx
);

	typedef enum logic [1:0] {
		S_WAIT,
		S_STRIDE,
		S_DELTA,
		S_RUN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] idx_q;
	logic          out_valid_q;
	logic          accept;

	// Items enter only once the strides are set up and the output can move.
	assign in_stall  = !((state_q == S_RUN) && (!out_valid_q || !out_stall));
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign cfg_ready = ((state_q == S_WAIT) || (state_q == S_RUN)) && !out_valid_q;
	assign idx       = idx_q;

	// Datapath commands.
	always_comb begin
		cmd.init      = (state_q == S_WAIT) && in_valid && !sts.cfg_hit;
		cmd.stride_en = (state_q == S_STRIDE);
		cmd.delta_en  = (state_q == S_DELTA);
		cmd.step      = accept;
	end

	// State, setup index and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WAIT;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (sts.cfg_hit) begin
				state_q <= S_WAIT;
			end else begin
				unique case (state_q)
					S_WAIT: begin
						if (in_valid) begin
							state_q <= S_STRIDE;
							idx_q   <= rank_last;
						end
					end
					S_STRIDE: begin
						if (idx_q == '0) begin
							state_q <= S_DELTA;
						end else begin
							idx_q <= idx_q - IW'(1);
						end
					end
					S_DELTA: begin
						if (idx_q == rank_last) begin
							state_q <= S_RUN;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
					S_RUN: begin
						state_q <= S_RUN;
					end
					default: begin
						state_q <= S_WAIT;
					end
				endcase
			end
		end
	end

	// An item is only taken once the setup has finished.
	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == S_RUN))
		else $error("item accepted outside of the run state");

	// Every accepted item shows up in the output register.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item did not reach the output register");

	// The setup index never passes the last dimension in use.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_STRIDE) || (state_q == S_DELTA)) |-> (idx_q <= rank_last))
		else $error("setup index beyond the rank");

	// A restarting register write forces a new stride setup.
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cfg_hit |=> (state_q == S_WAIT))
		else $error("register write did not restart the setup");

endmodule

// ===== dv/tb_top.sv =====
// Testbench of the column-major to row-major address unit, with a self-checking index scoreboard.
`timescale 1ns / 1ps

module tb_top;

	localparam int MAXR = cmrm_pkg::MAX_RANK_DEF;
	localparam int DW   = cmrm_pkg::DIM_BITS_DEF;
	localparam int IW   = cmrm_pkg::INDEX_BITS_DEF;
	localparam int XW   = cmrm_pkg::DATA_BITS_DEF;

	// Register indexes past the size registers are not decoded by the unit.
	localparam logic [cmrm_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_FIRST =
		cmrm_pkg::CFG_IDX_BITS'(cmrm_pkg::REG_DIM0 + cmrm_pkg::CFG_SIZE_REGS);
	localparam int RANDOM_ITEMS = 1100;

	// Tracks the tensor position of every accepted element and holds the
	// destination placements still to come out of the unit.
	class row_major_index_tracker;
		typedef struct {
			logic [IW-1:0] dest_index;
			logic [XW-1:0] element;
			logic          last;
			logic          overflow;
		} placement_t;

		logic [2:0]    rank_reg;
		logic [DW-1:0] size_reg [MAXR];
		logic [DW-1:0] digit [MAXR];
		logic [IW-1:0] stride [MAXR];
		logic [IW-1:0] offset;
		bit            strides_set;
		bit            overflow_flag;
		placement_t    pending_placements [$];
		int            errors;
		int            checked;
		int            tensors_done;
		int            overflow_items;

		function new();
			rank_reg = 3'd1;
			for (int k = 0; k < MAXR; k++) begin
				size_reg[k] = 1;
				stride[k] = 0;
			end
			overflow_flag = 0;
			errors = 0;
			checked = 0;
			tensors_done = 0;
			overflow_items = 0;
			restart_tensor();
		endfunction

		function void restart_tensor();
			for (int k = 0; k < MAXR; k++)
				digit[k] = 0;
			strides_set = 0;
			offset = 0;
		endfunction

		// Rank zero counts as one, and ranks above the maximum saturate.
		function int used_rank();
			int r;
			r = int'(rank_reg);
			if (r == 0)
				r = 1;
			if (r > MAXR)
				r = MAXR;
			return r;
		endfunction

		// A size of zero counts as one.
		function longint unsigned size_of(int k);
			return (size_reg[k] == 0) ? 64'd1 : 64'(size_reg[k]);
		endfunction

		function void write_reg(logic [2:0] idx, logic [DW-1:0] value);
			if (idx == cmrm_pkg::REG_RANK) begin
				rank_reg = value[2:0];
			end else if (idx >= cmrm_pkg::REG_DIM0 && idx < REG_UNUSED_FIRST) begin
				size_reg[int'(idx - cmrm_pkg::REG_DIM0)] = value;
			end else begin
				return;
			end
			overflow_flag = 0;
			restart_tensor();
		endfunction

		// Row-major strides: the last used dimension has stride one. The exact
		// element count of up to four 16-bit sizes still fits in 64 bits.
		function void setup_strides();
			longint unsigned count;
			logic [IW-1:0]   run;
			int              r;
			r = used_rank();
			count = 1;
			run = 1;
			for (int k = 0; k < MAXR; k++)
				stride[k] = 0;
			for (int k = r - 1; k >= 0; k--) begin
				stride[k] = run;
				run = run * IW'(size_of(k));
				count = count * size_of(k);
			end
			overflow_flag = count > (64'd1 << IW);
			strides_set = 1;
		endfunction

		function void note_element(logic [XW-1:0] data);
			placement_t    p;
			int            r;
			bit            at_end;
			bit            carry;
			logic [IW-1:0] sum;
			if (!strides_set)
				setup_strides();
			r = used_rank();
			at_end = 1;
			for (int k = 0; k < r; k++)
				if (64'(digit[k]) + 1 < size_of(k))
					at_end = 0;
			p.dest_index = offset;
			p.element = data;
			p.last = at_end;
			p.overflow = overflow_flag;
			pending_placements = {pending_placements, p};
			if (overflow_flag)
				overflow_items++;
			if (at_end) begin
				tensors_done++;
				restart_tensor();
				return;
			end
			// Advance the digit counters, dimension 0 fastest.
			carry = 1;
			for (int k = 0; k < r && carry; k++) begin
				if (64'(digit[k]) + 1 < size_of(k)) begin
					digit[k]++;
					carry = 0;
				end else begin
					digit[k] = 0;
				end
			end
			sum = 0;
			for (int k = 0; k < r; k++)
				sum = sum + IW'(digit[k]) * stride[k];
			offset = sum;
		endfunction

		function int pending();
			return pending_placements.size();
		endfunction

		function void check_result(logic [IW-1:0] dest, logic [XW-1:0] elem,
				logic last, logic ovf);
			placement_t p;
			if (pending_placements.size() == 0) begin
				$error("unexpected item: dest_index %0h element_out %0h", dest, elem);
				errors++;
				return;
			end
			p = pending_placements.pop_front();
			checked++;
			if (dest !== p.dest_index) begin
				$error("dest_index: expected %0h, actual %0h", p.dest_index, dest);
				errors++;
			end
			if (elem !== p.element) begin
				$error("element_out: expected %0h, actual %0h", p.element, elem);
				errors++;
			end
			if (last !== p.last) begin
				$error("last_element: expected %0b, actual %0b", p.last, last);
				errors++;
			end
			if (ovf !== p.overflow) begin
				$error("index_overflow: expected %0b, actual %0b", p.overflow, ovf);
				errors++;
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [cmrm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DW-1:0]                     cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [XW-1:0]                     element_in = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [IW-1:0]                     dest_index;
	logic [XW-1:0]                     element_out;
	logic                              last_element;
	logic                              index_overflow;

	row_major_index_tracker tracker;
	bit quiet = 0;
	int settings_count = 0;
	int random_count = 0;

	col_major_to_row_major_address_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.element_in     (element_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.dest_index     (dest_index),
		.element_out    (element_out),
		.last_element   (last_element),
		.index_overflow (index_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

	// Each idle roll comes up true about 16 times in a hundred, except in the quiet stretch.
	function automatic bit idle_roll();
		return !quiet && $urandom_range(99) < 16;
	endfunction

	// Receiver: check every item taken from the output, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(dest_index, element_out, last_element, index_overflow);
		out_stall <= idle_roll();
	end

	task automatic cfg_write(logic [cmrm_pkg::CFG_IDX_BITS-1:0] idx, logic [DW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, value);
	endtask

	task automatic cfg_close();
		cfg_valid <= 1'b0;
		settings_count++;
	endtask

	task automatic send_element(logic [XW-1:0] data);
		if (idle_roll()) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_in <= data;
		do @(posedge clk); while (in_stall);
		tracker.note_element(data);
	endtask

	// Stop sending and wait until every placed element has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [XW-1:0] random_element();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 10)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// A new tensor shape: mostly small sizes so that tensors close often,
	// now and then zero sizes, odd ranks, or sizes that overflow the index.
	task automatic random_settings();
		logic [cmrm_pkg::CFG_IDX_BITS-1:0] order [5];
		logic [cmrm_pkg::CFG_IDX_BITS-1:0] swap;
		logic [DW-1:0]                     value;
		int                                style;
		int                                writes;
		int                                j;
		int                                pick;
		style = $urandom_range(99);
		order[0] = cmrm_pkg::REG_RANK;
		for (int i = 1; i < 5; i++)
			order[i] = cmrm_pkg::CFG_IDX_BITS'(cmrm_pkg::REG_DIM0 + i - 1);
		for (int i = 4; i > 0; i--) begin
			j = $urandom_range(i);
			swap = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		writes = ($urandom_range(99) < 70) ? 5 : $urandom_range(1, 4);
		for (int i = 0; i < writes; i++) begin
			pick = $urandom_range(99);
			if (order[i] == cmrm_pkg::REG_RANK)
				value = (style < 10) ? DW'($urandom_range(7)) : DW'($urandom_range(1, 4));
			else if (style < 8 || pick < 5)
				value = DW'($urandom_range(16'hFFFF));
			else if (pick < 10)
				value = 0;
			else
				value = DW'($urandom_range(1, 4));
			cfg_write(order[i], value);
		end
		if ($urandom_range(99) < 15)
			cfg_write(cmrm_pkg::CFG_IDX_BITS'(REG_UNUSED_FIRST + $urandom_range(2)),
				DW'($urandom_range(16'hFFFF)));
		cfg_close();
	endtask

	initial begin
		int n;
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: rank one of size one, so every element closes a tensor.
		send_element('0);
		send_element('1);
		send_element({32{2'b10}});

		// Rank zero acts as rank one.
		drain();
		cfg_write(cmrm_pkg::REG_RANK, 0);
		cfg_write(cmrm_pkg::REG_DIM0, 3);
		cfg_close();
		repeat (3) send_element(random_element());

		// Rank seven saturates to four, and a zero size acts as one.
		drain();
		cfg_write(cmrm_pkg::REG_RANK, 7);
		cfg_write(cmrm_pkg::REG_DIM0, 2);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd1, 0);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd2, 2);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd3, 1);
		cfg_close();
		repeat (4) send_element(random_element());

		// Exactly 2^32 elements is still in range.
		drain();
		cfg_write(cmrm_pkg::REG_RANK, 4);
		for (int k = 0; k < 4; k++)
			cfg_write(cmrm_pkg::REG_DIM0 + cmrm_pkg::CFG_IDX_BITS'(k), 256);
		cfg_close();
		repeat (2) send_element(random_element());

		// One more in the slowest dimension overflows; writes to undecoded
		// indexes in the middle of the tensor must not restart it.
		drain();
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd3, 257);
		cfg_close();
		send_element(random_element());
		drain();
		cfg_write(REG_UNUSED_FIRST, 16'hFFFF);
		cfg_write(REG_UNUSED_FIRST + 3'd1, 0);
		cfg_write(REG_UNUSED_FIRST + 3'd2, 16'hFFFF);
		cfg_close();
		send_element(random_element());

		// Largest sizes in use, zero in the unused dimensions.
		drain();
		cfg_write(cmrm_pkg::REG_RANK, 2);
		cfg_write(cmrm_pkg::REG_DIM0, 16'hFFFF);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd1, 16'hFFFF);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd2, 0);
		cfg_write(cmrm_pkg::REG_DIM0 + 3'd3, 0);
		cfg_close();
		repeat (3) send_element(random_element());

		// Random shapes, each followed by a burst of elements.
		for (int phase = 0; random_count < RANDOM_ITEMS; phase++) begin
			drain();
			random_settings();
			n = $urandom_range(10, 90);
			if (n > RANDOM_ITEMS - random_count)
				n = RANDOM_ITEMS - random_count;
			for (int i = 0; i < n; i++) begin
				quiet = random_count >= 400 && random_count < 650;
				if (i == n / 2 && (phase == 2 || $urandom_range(99) < 10))
					drain();
				send_element(random_element());
				random_count++;
			end
		end
		drain();
		quiet = 0;
		repeat (20) @(posedge clk);

		if (tracker.pending() != 0) begin
			$error("%0d expected items never came out", tracker.pending());
			tracker.errors++;
		end
		$display("Checked %0d elements over %0d register settings.", tracker.checked,
			settings_count);
		$display("%0d tensors closed, %0d elements flagged with index overflow.",
			tracker.tensors_done, tracker.overflow_items);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== col_major_to_row_major_address_unit.f =====
hdl/cmrm_pkg.sv
hdl/cmrm_datapath.sv
hdl/cmrm_ctrl.sv
hdl/col_major_to_row_major_address_unit.sv
dv/tb_top.sv
